// ===== rtl/greedy_iou_box_suppression_defines.svh =====
// assertion macros for the greedy iou box suppression block
`ifndef GREEDY_IOU_BOX_SUPPRESSION_DEFINES_SVH
`define GREEDY_IOU_BOX_SUPPRESSION_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GIBS_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define GIBS_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gibs_pkg.sv =====
// shared types and constants of the greedy iou box suppression block
`default_nettype none

package gibs_pkg;

  localparam int THR_W = 9;
  localparam logic [THR_W-1:0] THR_RESET = 9'd102;

  localparam int IDX_W = 16;
  localparam logic [IDX_W-1:0] IDX_MAX = 16'hFFFF;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // register index, taken from paddr[2]
  localparam logic REG_THR_IDX = 1'b0;

  typedef struct packed {
    logic issue;
    logic clear;
  } gibs_cmp_ctl_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } gibs_cmp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/gibs_ram.sv =====
// generic single-port-write, registered-read ram
`default_nettype none

module gibs_ram #(
  parameter int WIDTH = 78,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/gibs_cmp.sv =====
// overlap test pipeline: one stored box per cycle against the current box
`default_nettype none

module gibs_cmp
  import gibs_pkg::*;
#(
  parameter int COORD_BITS = 13,
  localparam int C = COORD_BITS,
  localparam int AREA_W = 2 * C,
  localparam int UNI_W = AREA_W + 1,
  localparam int PROD_W = UNI_W + THR_W,
  localparam int WORD_W = 4 * C + AREA_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gibs_cmp_ctl_t        ctl,
  input  logic [THR_W-1:0]     thr,
  input  logic signed [C-1:0]  bx0,
  input  logic signed [C-1:0]  by0,
  input  logic signed [C-1:0]  bx1,
  input  logic signed [C-1:0]  by1,
  input  logic [AREA_W-1:0]    barea,
  input  logic [WORD_W-1:0]    rd_data,
  output gibs_cmp_stat_t       stat
);

  logic                p0_r, pa_r, pb_r, pc_r;
  logic                hit_r, hit_nxt;
  logic [C-1:0]        dxa_r, dya_r, dxa_nxt, dya_nxt;
  logic [AREA_W-1:0]   ka_r, kb_r, inter_r, interc_r;
  logic [UNI_W-1:0]    uni_r, uni_nxt;
  logic signed [C-1:0] kx0, ky0, kx1, ky1;
  logic signed [C-1:0] ix0, iy0, ix1, iy1;
  logic signed [C:0]   dxs, dys;
  logic [PROD_W-1:0]   prod, scaled;

  // stored word unpack
  always_comb begin
    kx0 = $signed(rd_data[WORD_W-1 -: C]);
    ky0 = $signed(rd_data[WORD_W-C-1 -: C]);
    kx1 = $signed(rd_data[WORD_W-2*C-1 -: C]);
    ky1 = $signed(rd_data[WORD_W-3*C-1 -: C]);
  end

  // intersection extents
  always_comb begin
    ix0 = (bx0 > kx0) ? bx0 : kx0;
    iy0 = (by0 > ky0) ? by0 : ky0;
    ix1 = (bx1 < kx1) ? bx1 : kx1;
    iy1 = (by1 < ky1) ? by1 : ky1;
    dxs = {ix1[C-1], ix1} - {ix0[C-1], ix0};
    dys = {iy1[C-1], iy1} - {iy0[C-1], iy0};
    if (ix1 > ix0 && iy1 > iy0) begin
      dxa_nxt = dxs[C-1:0];
      dya_nxt = dys[C-1:0];
    end else begin
      dxa_nxt = '0;
      dya_nxt = '0;
    end
  end

  assign uni_nxt = UNI_W'(barea) + UNI_W'(kb_r) - UNI_W'(inter_r);
  assign prod    = PROD_W'(thr) * PROD_W'(uni_r);
  assign scaled  = PROD_W'({interc_r, 8'd0});

  always_comb begin
    hit_nxt = hit_r;
    if (ctl.clear) begin
      hit_nxt = 1'b0;
    end else if (pc_r && uni_r != '0 && scaled > prod) begin
      hit_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_r  <= 1'b0;
      pa_r  <= 1'b0;
      pb_r  <= 1'b0;
      pc_r  <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      p0_r  <= ctl.issue;
      pa_r  <= p0_r;
      pb_r  <= pa_r;
      pc_r  <= pb_r;
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dxa_r    <= dxa_nxt;
    dya_r    <= dya_nxt;
    ka_r     <= rd_data[AREA_W-1:0];
    inter_r  <= AREA_W'(dxa_r) * AREA_W'(dya_r);
    kb_r     <= ka_r;
    uni_r    <= uni_nxt;
    interc_r <= inter_r;
  end

  assign stat.busy = p0_r | pa_r | pb_r | pc_r;
  assign stat.hit  = hit_r;

endmodule

`default_nettype wire

// ===== rtl/greedy_iou_box_suppression.sv =====
// top level of the greedy iou box suppression block
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_ready  start_of_set, corner pairs
//   out_     output     out_valid/out_ready keep, box_index, kept_count, list_full
//   cfg_     apb        psel/penable       overlap threshold at byte address 0
//
// one box at a time: a new box is accepted only when idle, after the last result is posted;
// each scan has the kept-box memory delivering one stored entry per cycle into a 4-stage test
// result sits in an output register; a stalled output holds the block in its final state
// rst_n is synchronous; the kept store holds no reset and the test never uses entries past kept_count
`default_nettype none
`include "greedy_iou_box_suppression_defines.svh"

module greedy_iou_box_suppression
  import gibs_pkg::*;
#(
  parameter int MAX_KEPT = 64,
  parameter int COORD_BITS = 13,
  localparam int C = COORD_BITS,
  localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1,
  localparam int KCW = $clog2(MAX_KEPT + 1),
  localparam int AREA_W = 2 * C,
  localparam int WORD_W = 4 * C + AREA_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_start_of_set,
  input  logic signed [C-1:0]   in_x_first,
  input  logic signed [C-1:0]   in_y_first,
  input  logic signed [C-1:0]   in_x_second,
  input  logic signed [C-1:0]   in_y_second,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_keep,
  output logic [IDX_W-1:0]      out_box_index,
  output logic [KCW-1:0]        out_kept_count,
  output logic                  out_list_full,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_AREA = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [KCW-1:0] KEPT_MAX = KCW'(MAX_KEPT);

  logic [1:0]          state_r, state_nxt;
  logic [THR_W-1:0]    thr_r, thr_nxt;
  logic [KCW-1:0]      kept_total_r, kept_total_nxt;
  logic [KCW-1:0]      issue_r, issue_nxt;
  logic [IDX_W-1:0]    pos_r, pos_nxt;
  logic [IDX_W-1:0]    idx_r;
  logic signed [C-1:0] bx0_r, by0_r, bx1_r, by1_r;
  logic [AREA_W-1:0]   area_r;
  logic signed [C:0]   wxs, wys;
  logic                out_valid_r, out_valid_nxt;
  logic                out_keep_r, out_list_full_r;
  logic [IDX_W-1:0]    out_box_index_r;
  logic [KCW-1:0]      out_kept_count_r;

  logic                in_fire, post, keep, has_room, wr_en, cfg_wr, cfg_hit;
  logic [IDX_W-1:0]    pos_base;
  logic [WORD_W-1:0]   rd_data;
  gibs_cmp_ctl_t       cmp_ctl;
  gibs_cmp_stat_t      cmp_stat;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign pos_base = in_start_of_set ? '0 : pos_r;

  assign post     = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign keep     = !cmp_stat.hit;
  assign has_room = (kept_total_r < KEPT_MAX);
  assign wr_en    = post && keep && has_room;

  assign wxs = {bx1_r[C-1], bx1_r} - {bx0_r[C-1], bx0_r};
  assign wys = {by1_r[C-1], by1_r} - {by0_r[C-1], by0_r};

  assign cmp_ctl.issue = (state_r == S_SCAN) && (issue_r < kept_total_r);
  assign cmp_ctl.clear = in_fire;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == REG_THR_IDX);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_hit ? CFG_DATA_W'(thr_r) : '0;
  assign thr_nxt    = (cfg_wr && cfg_hit) ? cfg_pwdata[THR_W-1:0] : thr_r;

  always_comb begin
    state_nxt      = state_r;
    kept_total_nxt = kept_total_r;
    issue_nxt      = issue_r;
    pos_nxt        = pos_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_AREA;
          pos_nxt   = (pos_base == IDX_MAX) ? pos_base : pos_base + 1'b1;
          if (in_start_of_set) begin
            kept_total_nxt = '0;
          end
        end
      end
      S_AREA: begin
        issue_nxt = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (cmp_ctl.issue) begin
          issue_nxt = issue_r + 1'b1;
        end else if (!cmp_stat.busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (post) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (wr_en) begin
            kept_total_nxt = kept_total_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      thr_r        <= THR_RESET;
      kept_total_r <= '0;
      issue_r      <= '0;
      pos_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      thr_r        <= thr_nxt;
      kept_total_r <= kept_total_nxt;
      issue_r      <= issue_nxt;
      pos_r        <= pos_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      idx_r <= pos_base;
      bx0_r <= (in_x_first < in_x_second) ? in_x_first : in_x_second;
      bx1_r <= (in_x_first < in_x_second) ? in_x_second : in_x_first;
      by0_r <= (in_y_first < in_y_second) ? in_y_first : in_y_second;
      by1_r <= (in_y_first < in_y_second) ? in_y_second : in_y_first;
    end
    if (state_r == S_AREA) begin
      area_r <= AREA_W'(wxs[C-1:0]) * AREA_W'(wys[C-1:0]);
    end
    if (post) begin
      out_keep_r       <= keep;
      out_list_full_r  <= keep && !has_room;
      out_box_index_r  <= idx_r;
      out_kept_count_r <= wr_en ? kept_total_r + 1'b1 : kept_total_r;
    end
  end

  gibs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_KEPT)
  ) u_kept_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (kept_total_r[AW-1:0]),
    .wr_data ({bx0_r, by0_r, bx1_r, by1_r, area_r}),
    .rd_addr (issue_r[AW-1:0]),
    .rd_data (rd_data)
  );

  gibs_cmp #(
    .COORD_BITS (COORD_BITS)
  ) u_cmp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (cmp_ctl),
    .thr     (thr_r),
    .bx0     (bx0_r),
    .by0     (by0_r),
    .bx1     (bx1_r),
    .by1     (by1_r),
    .barea   (area_r),
    .rd_data (rd_data),
    .stat    (cmp_stat)
  );

  assign out_valid      = out_valid_r;
  assign out_keep       = out_keep_r;
  assign out_box_index  = out_box_index_r;
  assign out_kept_count = out_kept_count_r;
  assign out_list_full  = out_list_full_r;

  `GIBS_ASSERT_IMP(a_total_bound, clk, rst_n, 1'b1, kept_total_r <= KEPT_MAX, "kept total over depth")
  `GIBS_ASSERT_IMP(a_write_room, clk, rst_n, wr_en, has_room && state_r == S_DONE, "store write when full")
  `GIBS_ASSERT_IMP(a_scan_bound, clk, rst_n, state_r == S_SCAN, issue_r <= kept_total_r, "read past kept entries")
  `GIBS_ASSERT_NXT(a_full_keeps, clk, rst_n, post, out_keep_r || !out_list_full_r, "full flag on suppressed box")

endmodule

`default_nettype wire
